// ===== sv/bidt_pkg.sv =====
// shared types and constants of the bitmap id table
package bidt_pkg;

  localparam int ID_BITS     = 6;
  localparam int CNT_BITS    = 7;
  localparam int WORD_BITS   = 32;
  localparam int CHUNK       = 32;
  localparam int CHUNK_BITS  = 5;
  localparam int CFG_ADDR_BITS = 3;

  localparam logic [CNT_BITS-1:0] ACTIVE_RESET = 7'd64;
  // word select bit of paddr for the one register
  localparam logic REG_ACTIVE_ENTRIES = 1'b0;

  typedef enum logic [2:0] {
    OP_FIND      = 3'd0,
    OP_INSTALL   = 3'd1,
    OP_UNINSTALL = 3'd2,
    OP_SET       = 3'd3,
    OP_GET       = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_PERM   = 2'd1,
    ST_RANGE  = 2'd2,
    ST_NODATA = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0]           cmd;
    logic [ID_BITS-1:0]   id;
    logic [WORD_BITS-1:0] write_data;
    logic                 data_present;
  } req_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [WORD_BITS-1:0] read_data;
    logic [CNT_BITS-1:0]  free_id;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic apply;
    logic scan;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic is_find;
    logic scan_end;
  } sts_t;

endpackage

// ===== sv/bitmap_id_table_top.sv =====
// top level of the bitmap id table: register port, controller and datapath
// done is registered: a non-find command raises it as it leaves the check state, a find when
//   its scan ends; a find scans the bitmap chunk by chunk until a free id turns up (2 chunks at the
//   default depth of 64, at most 4 for 127 ids); a new command is taken only in idle
// reset: bitmap cleared at once, active_entries back to 64, no clearing pass
// results are shown for one cycle on done; the receiver cannot stall
module bitmap_id_table_top #(
  parameter int DEPTH     = 64,
  parameter int DATA_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  // register port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bidt_pkg::CFG_ADDR_BITS-1:0]  paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  // command channel
  input  logic                                start,
  output logic                                busy,
  input  bidt_pkg::req_t                      req,
  // result channel
  output logic                                done,
  output bidt_pkg::rsp_t                      rsp
);

  logic [bidt_pkg::CNT_BITS-1:0] active_entries;
  logic                          reg_hit;
  bidt_pkg::ctl_t                ctl;
  bidt_pkg::sts_t                sts;

  // zero wait states; the low two address bits pick a byte lane and are ignored
  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == bidt_pkg::REG_ACTIVE_ENTRIES);

  // word read: the active count register, zero elsewhere
  assign prdata = reg_hit ? 32'(active_entries) : '0;

  // word write on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      active_entries <= bidt_pkg::ACTIVE_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      active_entries <= pwdata[bidt_pkg::CNT_BITS-1:0];
    end
  end

  // sequencing: capture, check and apply, or scan for a free id
  bidt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .ctl   (ctl),
    .sts   (sts)
  );

  // bitmap, entry memory and the registered result word
  bidt_dpath #(
    .DEPTH     (DEPTH),
    .DATA_BITS (DATA_BITS)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl),
    .sts            (sts),
    .req            (req),
    .active_entries (active_entries),
    .rsp            (rsp)
  );

endmodule

// ===== sv/bidt_ctrl.sv =====
// sequencing state machine of the bitmap id table
module bidt_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  output logic           done,
  output bidt_pkg::ctl_t ctl,
  input  bidt_pkg::sts_t sts
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN
  } state_t;

  state_t state;

  assign busy        = (state != S_IDLE);
  assign ctl.capture = start && (state == S_IDLE);
  assign ctl.apply   = (state == S_CHECK) && !sts.is_find;
  assign ctl.scan    = (state == S_SCAN);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) state <= S_CHECK;
        end
        S_CHECK: begin
          if (sts.is_find) begin
            state <= S_SCAN;
          end else begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_SCAN: begin
          if (sts.scan_end) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/bidt_dpath.sv =====
// occupancy bitmap, entry memory, chunk scanner and result register
module bidt_dpath #(
  parameter int DEPTH     = 64,
  parameter int DATA_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  bidt_pkg::ctl_t                    ctl,
  output bidt_pkg::sts_t                    sts,
  input  bidt_pkg::req_t                    req,
  input  logic [bidt_pkg::CNT_BITS-1:0]     active_entries,
  output bidt_pkg::rsp_t                    rsp
);

  localparam int CHUNK  = bidt_pkg::CHUNK;
  localparam int CB     = bidt_pkg::CHUNK_BITS;
  localparam int CW     = bidt_pkg::CNT_BITS;
  localparam int NCHUNK = (DEPTH + CHUNK - 1) / CHUNK;
  localparam int IDXW   = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int PW     = (IDXW + CB + 1 > CW + 1) ? IDXW + CB + 1 : CW + 1;
  localparam int AW     = $clog2(DEPTH);
  localparam int WIDE   = (DATA_BITS > bidt_pkg::WORD_BITS) ? DATA_BITS
                                                            : bidt_pkg::WORD_BITS;
  localparam int CAP    = (DEPTH > 127) ? 127 : DEPTH;

  bidt_pkg::req_t               req_q;
  logic [DATA_BITS-1:0]         mem [DEPTH];
  logic [DATA_BITS-1:0]         mem_q;
  logic [NCHUNK*CHUNK-1:0]      bmap;
  logic [IDXW-1:0]              scan_idx;

  logic [CW-1:0]                count;
  logic [AW-1:0]                in_addr;
  logic [AW-1:0]                addr;
  logic                         in_range;
  logic                         used;
  logic [WIDE-1:0]              w_wide;
  logic [WIDE-1:0]              r_wide;
  logic [DATA_BITS-1:0]         wdata;
  logic [1:0]                   st;
  logic                         set_bit;
  logic                         clr_bit;
  logic                         we;
  logic [DATA_BITS-1:0]         wd;
  logic                         get_ok;

  logic [CHUNK-1:0]             chunk;
  logic [CHUNK-1:0]             free_bits;
  logic [CB-1:0]                pe;
  logic                         hit;
  logic                         last;

  assign count    = (active_entries > CW'(CAP)) ? CW'(CAP) : active_entries;
  assign in_addr  = AW'(req.id);
  assign addr     = AW'(req_q.id);
  assign in_range = {1'b0, req_q.id} < count;
  assign used     = bmap[addr];
  assign w_wide   = WIDE'(req_q.write_data);
  assign wdata    = w_wide[DATA_BITS-1:0];
  assign r_wide   = WIDE'(mem_q);

  // an install without data writes zero; the entry memory is not cleared on uninstall or reset
  always_comb begin
    st      = bidt_pkg::ST_OK;
    set_bit = 1'b0;
    clr_bit = 1'b0;
    we      = 1'b0;
    wd      = '0;
    get_ok  = 1'b0;
    if (req_q.cmd > 3'(bidt_pkg::OP_GET)) begin
      st = bidt_pkg::ST_PERM;
    end else if (!in_range) begin
      st = bidt_pkg::ST_RANGE;
    end else begin
      unique case (req_q.cmd)
        bidt_pkg::OP_INSTALL: begin
          if (used) begin
            st = bidt_pkg::ST_PERM;
          end else begin
            set_bit = 1'b1;
            we      = 1'b1;
            wd      = req_q.data_present ? wdata : '0;
          end
        end
        bidt_pkg::OP_UNINSTALL: begin
          if (!used) st = bidt_pkg::ST_PERM;
          else clr_bit = 1'b1;
        end
        bidt_pkg::OP_SET: begin
          if (!req_q.data_present) begin
            st = bidt_pkg::ST_NODATA;
          end else if (!used) begin
            st = bidt_pkg::ST_PERM;
          end else begin
            we = 1'b1;
            wd = wdata;
          end
        end
        bidt_pkg::OP_GET: begin
          if (!used) st = bidt_pkg::ST_PERM;
          else get_ok = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // one chunk of the bitmap per scan cycle, ids at or above count read as used
  assign chunk = bmap[{scan_idx, CB'(0)} +: CHUNK];

  always_comb begin
    for (int j = 0; j < CHUNK; j++) begin
      free_bits[j] = !chunk[j] && (PW'({scan_idx, CB'(j)}) < PW'(count));
    end
  end

  always_comb begin
    pe = '0;
    for (int j = CHUNK - 1; j >= 0; j--) begin
      if (free_bits[j]) pe = CB'(j);
    end
  end

  assign hit  = |free_bits;
  assign last = (PW'({scan_idx, CB'(0)}) + PW'(CHUNK)) >= PW'(count);

  assign sts.is_find  = (req_q.cmd == bidt_pkg::OP_FIND);
  assign sts.scan_end = hit || last;

  always_ff @(posedge clk) begin
    if (ctl.capture) req_q <= req;
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) mem_q <= mem[in_addr];
  end

  always_ff @(posedge clk) begin
    if (ctl.apply && we) mem[addr] <= wd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bmap <= '0;
    end else if (ctl.apply) begin
      if (set_bit) bmap[addr] <= 1'b1;
      if (clr_bit) bmap[addr] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      scan_idx <= '0;
    end else if (ctl.scan && !sts.scan_end) begin
      scan_idx <= scan_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.apply) begin
      rsp.status    <= st;
      rsp.read_data <= get_ok ? r_wide[bidt_pkg::WORD_BITS-1:0] : '0;
      rsp.free_id   <= '0;
    end else if (ctl.scan && sts.scan_end) begin
      rsp.status    <= bidt_pkg::ST_OK;
      rsp.read_data <= '0;
      rsp.free_id   <= hit ? CW'({scan_idx, pe}) : count;
    end
  end

endmodule
